@@ hw/rtl/rtrp_pkg.sv @@
// Shared types and constants for the text run parser.
`timescale 1ns / 1ps

package rtrp_pkg;

  // Delimiter characters of the run syntax
  localparam logic [7:0] CharOpen  = 8'h7B;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharClose = 8'h7D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Parse phase, one-hot
  typedef enum logic [3:0] {
    PH_WAIT  = 4'b0001,
    PH_VALUE = 4'b0010,
    PH_COMMA = 4'b0100,
    PH_COUNT = 4'b1000
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_DELIM = 3'd1,
    ERR_DIGIT = 3'd2,
    ERR_EMPTY = 3'd3,
    ERR_ZERO  = 3'd4
  } err_e;

endpackage

@@ hw/rtl/rtrp_byte_if.sv @@
// Valid/ready channel carrying one compressed stream byte per request.
`timescale 1ns / 1ps

interface rtrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ hw/rtl/rtrp_run_if.sv @@
// Valid/ready channel carrying one run descriptor or error per request.
`timescale 1ns / 1ps

interface rtrp_run_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_value;
  logic [7:0] run_length;
  logic [2:0] error_code;

  modport source (output valid, output run_value, output run_length,
                  output error_code, input ready);
  modport sink   (input valid, input run_value, input run_length,
                  input error_code, output ready);
endinterface

@@ hw/rtl/rle_text_run_parser_top.sv @@
// Text run parser: turns '{' value ',' digits '}' byte streams into run descriptors.
//
// Channels: byte_i takes one compressed byte per request; run_o gives one
// descriptor (run_value, run_length 1..255, error_code ERR_OK) per well-formed
// run, or one error request (value and length zero) per malformed run.
// Bytes that only advance the parse give no request on run_o.
// A byte accepted on byte_i is held in the input register and parsed
// there; the descriptor it closes is loaded into the result register and
// shown on run_o.
// Throughput: one byte per cycle unless a result stalls on run_o, set by
// the single parse step between the input and result registers. The parse
// state updates in that step, so consecutive bytes never wait on each other.
// Reset: clears both pipeline valids and returns the parser to waiting for
// an opening brace with an empty count.
// Stall: while a result waits on run_o the parse step holds, so the byte in
// the input register waits whether or not it would produce a result; one
// more byte is taken if the input register is empty, and byte_i.ready drops
// while both registers are full and run_o.ready is low.
`timescale 1ns / 1ps

module rle_text_run_parser_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  rtrp_byte_if.sink         byte_i,
  rtrp_run_if.source        run_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parse state
  rtrp_pkg::phase_e phase_q, phase_d;
  logic [7:0]       held_value_q, held_value_d;
  logic [7:0]       count_q, count_d;
  logic             digit_seen_q, digit_seen_d;

  // Result register
  logic       out_valid_q;
  logic [7:0] out_value_q;
  logic [7:0] out_length_q;
  rtrp_pkg::err_e out_err_q;

  // Parse step results
  logic           res_valid;
  logic [7:0]     res_value;
  logic [7:0]     res_length;
  rtrp_pkg::err_e res_err;
  logic           is_digit;
  logic [7:0]     digit_val;
  logic [7:0]     count_next;

  logic out_free;
  logic step_fire;

  assign out_free     = !out_valid_q || run_o.ready;
  assign step_fire    = in_valid_q && out_free;
  assign byte_i.ready = !in_valid_q || out_free;

  // Digit decode and count update, count*10 + digit kept to 8 bits
  assign is_digit   = (in_byte_q >= rtrp_pkg::CharZero) && (in_byte_q <= rtrp_pkg::CharNine);
  assign digit_val  = in_byte_q - rtrp_pkg::CharZero;
  assign count_next = {count_q[4:0], 3'b000} + {count_q[6:0], 1'b0} + digit_val;

  // Parse one byte
  always_comb begin
    phase_d      = phase_q;
    held_value_d = held_value_q;
    count_d      = count_q;
    digit_seen_d = digit_seen_q;
    res_valid    = 1'b0;
    res_value    = 8'd0;
    res_length   = 8'd0;
    res_err      = rtrp_pkg::ERR_OK;
    case (phase_q)
      rtrp_pkg::PH_WAIT: begin
        if (in_byte_q == rtrp_pkg::CharOpen) begin
          phase_d = rtrp_pkg::PH_VALUE;
        end else begin
          res_valid = 1'b1;
          res_err   = rtrp_pkg::ERR_DELIM;
        end
      end
      rtrp_pkg::PH_VALUE: begin
        held_value_d = in_byte_q;
        phase_d      = rtrp_pkg::PH_COMMA;
      end
      rtrp_pkg::PH_COMMA: begin
        if (in_byte_q == rtrp_pkg::CharComma) begin
          count_d      = 8'd0;
          digit_seen_d = 1'b0;
          phase_d      = rtrp_pkg::PH_COUNT;
        end else begin
          res_valid = 1'b1;
          res_err   = rtrp_pkg::ERR_DELIM;
        end
      end
      rtrp_pkg::PH_COUNT: begin
        if (in_byte_q == rtrp_pkg::CharClose) begin
          res_valid = 1'b1;
          if (!digit_seen_q) begin
            res_err = rtrp_pkg::ERR_EMPTY;
          end else if (count_q == 8'd0) begin
            res_err = rtrp_pkg::ERR_ZERO;
          end else begin
            res_value  = held_value_q;
            res_length = count_q;
          end
        end else if (is_digit) begin
          count_d      = count_next;
          digit_seen_d = 1'b1;
        end else begin
          res_valid = 1'b1;
          res_err   = rtrp_pkg::ERR_DIGIT;
        end
      end
      default: begin
        phase_d = rtrp_pkg::PH_WAIT;
      end
    endcase
    // Any result ends the run: clear back to waiting
    if (res_valid) begin
      phase_d      = rtrp_pkg::PH_WAIT;
      held_value_d = 8'd0;
      count_d      = 8'd0;
      digit_seen_d = 1'b0;
    end
  end

  // Capture input requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_valid_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.in_byte;
    end
  end

  // Advance parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= rtrp_pkg::PH_WAIT;
      held_value_q <= 8'd0;
      count_q      <= 8'd0;
      digit_seen_q <= 1'b0;
    end else if (step_fire) begin
      phase_q      <= phase_d;
      held_value_q <= held_value_d;
      count_q      <= count_d;
      digit_seen_q <= digit_seen_d;
    end
  end

  // Hold or load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire) begin
      out_valid_q <= res_valid;
    end else if (run_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && res_valid) begin
      out_value_q  <= res_value;
      out_length_q <= res_length;
      out_err_q    <= res_err;
    end
  end

  assign run_o.valid      = out_valid_q;
  assign run_o.run_value  = out_value_q;
  assign run_o.run_length = out_length_q;
  assign run_o.error_code = out_err_q;

  // Error results carry no run
  a_err_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q != rtrp_pkg::ERR_OK) |->
      (out_value_q == 8'd0 && out_length_q == 8'd0))
    else $error("error result carries nonzero payload");

  // Good results never have zero length
  a_ok_nonzero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q == rtrp_pkg::ERR_OK) |-> (out_length_q != 8'd0))
    else $error("ok result with zero length");

  // Count stays empty until a digit arrives
  a_count_needs_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !digit_seen_q |-> (count_q == 8'd0))
    else $error("count accumulated without a digit");

  // Waiting phase holds a cleared run
  a_wait_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rtrp_pkg::PH_WAIT) |-> (held_value_q == 8'd0 && !digit_seen_q))
    else $error("stale run state while waiting for open brace");

endmodule

@@ dv/rtrp_run_checker.sv @@
// Checker for the text run parser: predicts run descriptors and compares results.
`timescale 1ns / 1ps

module rtrp_run_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rtrp_byte_if byte_i,
  rtrp_run_if  run_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [7:0]     value;
    logic [7:0]     length;
    rtrp_pkg::err_e code;
  } run_desc_t;

  // Predicted parser state
  rtrp_pkg::phase_e phase_q;
  logic [7:0]       run_value_q;
  logic [7:0]       count_q;
  logic             digit_seen_q;

  run_desc_t  pending_runs[$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void drop_run_state();
    phase_q      = rtrp_pkg::PH_WAIT;
    run_value_q  = 8'd0;
    count_q      = 8'd0;
    digit_seen_q = 1'b0;
  endfunction

  // Queue one descriptor and start over at the opening brace
  function automatic void post_run(input logic [7:0] value, input logic [7:0] length,
                                   input rtrp_pkg::err_e code);
    run_desc_t desc;
    desc.value  = value;
    desc.length = length;
    desc.code   = code;
    pending_runs.push_back(desc);
    drop_run_state();
  endfunction

  // Advance the predicted parse by one byte
  function automatic void parse_byte(input logic [7:0] ch);
    case (phase_q)
      rtrp_pkg::PH_WAIT: begin
        if (ch != rtrp_pkg::CharOpen) post_run(8'd0, 8'd0, rtrp_pkg::ERR_DELIM);
        else phase_q = rtrp_pkg::PH_VALUE;
      end
      rtrp_pkg::PH_VALUE: begin
        run_value_q = ch;
        phase_q     = rtrp_pkg::PH_COMMA;
      end
      rtrp_pkg::PH_COMMA: begin
        if (ch != rtrp_pkg::CharComma) begin
          post_run(8'd0, 8'd0, rtrp_pkg::ERR_DELIM);
        end else begin
          count_q      = 8'd0;
          digit_seen_q = 1'b0;
          phase_q      = rtrp_pkg::PH_COUNT;
        end
      end
      default: begin
        if (ch == rtrp_pkg::CharClose) begin
          if (!digit_seen_q) post_run(8'd0, 8'd0, rtrp_pkg::ERR_EMPTY);
          else if (count_q == 8'd0) post_run(8'd0, 8'd0, rtrp_pkg::ERR_ZERO);
          else post_run(run_value_q, count_q, rtrp_pkg::ERR_OK);
        end else if (ch < rtrp_pkg::CharZero || ch > rtrp_pkg::CharNine) begin
          post_run(8'd0, 8'd0, rtrp_pkg::ERR_DIGIT);
        end else begin
          // count wraps at 8 bits
          count_q      = count_q * 8'd10 + (ch - rtrp_pkg::CharZero);
          digit_seen_q = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: run mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Compare one accepted result with the oldest prediction
  task automatic check_run();
    run_desc_t want;
    if (pending_runs.size() == 0) begin
      report_mismatch("unexpected request", 1, 0);
    end else begin
      want = pending_runs.pop_front();
      if (run_i.run_value !== want.value)
        report_mismatch("run_value", int'(run_i.run_value), int'(want.value));
      if (run_i.run_length !== want.length)
        report_mismatch("run_length", int'(run_i.run_length), int'(want.length));
      if (run_i.error_code !== want.code)
        report_mismatch("error_code", int'(run_i.error_code), int'(want.code));
    end
  endtask

  // Watch both channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_run_state();
      pending_runs.delete();
      pending_o = 0;
    end else begin
      if (run_i.valid && run_i.ready) check_run();
      if (byte_i.valid && byte_i.ready) parse_byte(byte_i.in_byte);
      pending_o = pending_runs.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// Testbench top for the text run parser: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;

  logic clk_i = 1'b0;
  logic rst_ni;

  rtrp_byte_if byte_if ();
  rtrp_run_if  run_if ();

  int mismatches;
  int runs_pending;
  int burst_left = 0;
  int bytes_sent = 0;
  int hold_requests = 0;

  rle_text_run_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .run_o  (run_if)
  );

  rtrp_run_checker run_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_if),
    .run_i        (run_if),
    .fail_count_o (mismatches),
    .pending_o    (runs_pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Bound the run
  initial begin
    #1ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall modes, plus long hold-offs on request
  initial begin
    int hold_left;
    int holds_served;
    int mode;
    int mode_left;
    int phase_cnt;
    logic [7:0] pattern;
    hold_left    = 0;
    holds_served = 0;
    mode         = 0;
    mode_left    = 0;
    phase_cnt    = 0;
    pattern      = 8'hA5;
    run_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = 200;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
        pattern   = 8'($urandom_range(0, 255));
      end
      mode_left--;
      phase_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        run_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       run_if.ready <= 1'b1;
          1:       run_if.ready <= 1'($urandom_range(0, 1));
          2:       run_if.ready <= ($urandom_range(0, 3) == 0);
          default: run_if.ready <= pattern[phase_cnt[2:0]];
        endcase
      end
    end
  end

  // Offer one byte and hold it until accepted; gaps fall between bursts
  task automatic push_byte(input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 32);
      if (gap != 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    bytes_sent++;
    byte_if.valid   <= 1'b1;
    byte_if.in_byte <= ch;
    do @(posedge clk_i); while (!byte_if.ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic send_digits(input int n);
    for (int i = 0; i < n; i++) push_byte(rtrp_pkg::CharZero + 8'($urandom_range(0, 9)));
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain_runs();
    byte_if.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk_i);
    while (runs_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_good_run();
    int ndig;
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
    push_byte(rtrp_pkg::CharOpen);
    push_byte(8'($urandom_range(0, 255)));
    push_byte(rtrp_pkg::CharComma);
    send_digits(ndig);
    push_byte(rtrp_pkg::CharClose);
  endtask

  // Malformed runs of every kind, plus stray bytes
  task automatic send_broken_run();
    logic [7:0] ch;
    case ($urandom_range(0, 4))
      0: push_byte(8'($urandom_range(0, 255)));
      1: begin
        push_byte(rtrp_pkg::CharOpen);
        push_byte(8'($urandom_range(0, 255)));
        do ch = 8'($urandom_range(0, 255)); while (ch == rtrp_pkg::CharComma);
        push_byte(ch);
      end
      2: begin
        push_byte(rtrp_pkg::CharOpen);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(rtrp_pkg::CharComma);
        send_digits($urandom_range(0, 2));
        do ch = 8'($urandom_range(0, 255));
        while ((ch >= rtrp_pkg::CharZero && ch <= rtrp_pkg::CharNine) ||
               ch == rtrp_pkg::CharClose);
        push_byte(ch);
      end
      3: begin
        push_byte(rtrp_pkg::CharOpen);
        push_byte(8'($urandom_range(0, 255)));
        send_text(",}");
      end
      default: begin
        push_byte(rtrp_pkg::CharOpen);
        push_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0:       send_text(",0}");
          1:       send_text(",256}");
          2:       send_text(",512}");
          default: send_text(",000}");
        endcase
      end
    endcase
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni          <= 1'b0;
    byte_if.valid   <= 1'b0;
    byte_if.in_byte <= 8'd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: longest run of the top value, stray byte, value bytes that
    // look like delimiters, an empty count, and a count that wraps to zero
    push_byte(rtrp_pkg::CharOpen);
    push_byte(8'hFF);
    send_text(",255}");
    send_text("x");
    send_text("{};");
    send_text("{,9x");
    send_text("{a,}");
    send_text("{{,256}");
    drain_runs();

    // Hold the receiver off while runs keep coming, so the input backs up
    hold_requests++;
    for (int i = 0; i < 10; i++) send_good_run();

    // Random: mostly well-formed runs, some broken ones and noise
    while (bytes_sent < 430) begin
      if ($urandom_range(0, 4) != 0) send_good_run();
      else send_broken_run();
      if (bytes_sent > 230 && bytes_sent < 240) drain_runs();
    end

    drain_runs();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
